### rtl/bottling_relay_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Bottling relay sequencer assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOTTLING_RELAY_SEQUENCER_UNIT_DEFINES_SVH
`define BOTTLING_RELAY_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent and consequent checked in the same cycle.
`define BRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BRS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BRS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// Bottling relay sequencer package
// Word types, register indexes, step codes and reset values shared by the
// sequencer modules.
// ----------------------------------------------------------------------------
package brs_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BELT_TIMEOUT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUSH           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAP            = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE         = 3'd6;

    // Step codes. Code zero is never entered.
    typedef logic [1:0] step_t;
    localparam step_t STEP_NONE = 2'd0;
    localparam step_t STEP_LOAD = 2'd1;
    localparam step_t STEP_PUSH = 2'd2;
    localparam step_t STEP_FILL = 2'd3;

    // Timer slots, in firing order.
    localparam int NUM_TIMERS = 7;
    localparam int T_BELT     = 0;
    localparam int T_PUSH     = 1;
    localparam int T_CAP      = 2;
    localparam int T_FOPEN    = 3;
    localparam int T_FCLOSE   = 4;
    localparam int T_CLAMP    = 5;
    localparam int T_SETTLE   = 6;

    typedef struct packed {
        logic [8:0]  near_threshold_cm;
        logic [15:0] belt_timeout_ms;
        logic [15:0] push_ms;
        logic [15:0] cap_ms;
        logic [15:0] fill_ms;
        logic [15:0] release_ms;
        logic [15:0] settle_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        near_threshold_cm: 9'd4,
        belt_timeout_ms:   16'd60000,
        push_ms:           16'd2500,
        cap_ms:            16'd1000,
        fill_ms:           16'd16000,
        release_ms:        16'd1000,
        settle_ms:         16'd1000
    };

    // Sequencer control state.
    typedef struct packed {
        step_t step;
        logic  busy;
        logic  detect;
        logic  loading;
        logic  clamp;
        logic  cap;
        logic  push;
        logic  fill;
        logic  belt;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        step:    STEP_LOAD,
        busy:    1'b0,
        detect:  1'b0,
        loading: 1'b0,
        clamp:   1'b0,
        cap:     1'b0,
        push:    1'b0,
        fill:    1'b0,
        belt:    1'b0
    };

    typedef struct packed {
        logic [15:0] elapsed_ms;
        logic [19:0] echo_us;
    } in_t;

    typedef struct packed {
        logic        clamp_on;
        logic        cap_on;
        logic        push_on;
        logic        fill_on;
        logic        belt_on;
        logic [1:0]  current_step;
        logic        step_busy;
        logic        bottle_seen;
    } out_t;

endpackage

### rtl/brs_near.sv
// ----------------------------------------------------------------------------
// Bottling relay sequencer near-bottle detector
// Compares the echo distance against the near threshold without a divider.
// ----------------------------------------------------------------------------
module brs_near (
    input  logic [19:0] echo_us,
    input  logic [8:0]  near_threshold_cm,
    output logic        near
);

    // floor(echo*17/1000) <= thr holds exactly when echo*17 < (thr+1)*1000.
    logic [24:0] echo_x17;
    logic [18:0] near_limit;

    assign echo_x17   = {1'b0, echo_us, 4'b0000} + 25'(echo_us);
    assign near_limit = (19'(near_threshold_cm) + 19'd1) * 19'd1000;
    assign near       = (echo_x17 < 25'(near_limit));

endmodule

### rtl/brs_pass.sv
// ----------------------------------------------------------------------------
// Bottling relay sequencer control pass
// One control pass: timer aging, step start, timer firing and bottle check.
// ----------------------------------------------------------------------------
module brs_pass #(
    parameter int TIMER_WIDTH = 18
) (
    input  brs_pkg::cfg_t             cfg,
    input  brs_pkg::in_t              item,
    input  brs_pkg::ctrl_t            ctrl_cur,
    input  logic [6:0]                pend_cur,
    input  logic [TIMER_WIDTH-1:0]    rem_cur [7],
    output brs_pkg::ctrl_t            ctrl_next,
    output logic [6:0]                pend_next,
    output logic [TIMER_WIDTH-1:0]    rem_next [7]
);

    localparam int SAT_W = (TIMER_WIDTH > 18) ? TIMER_WIDTH : 18;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    // Durations above the timer range clamp to the largest count.
    function automatic logic [TIMER_WIDTH-1:0] sat_dur(input logic [17:0] dur);
        logic [SAT_W-1:0] dx;
        dx = SAT_W'(dur);
        if (dx > SAT_W'(TMAX)) begin
            return TMAX;
        end
        return TIMER_WIDTH'(dx);
    endfunction

    logic [TIMER_WIDTH-1:0] elapsed_w;
    logic [17:0]            fclose_dur;
    logic [17:0]            clamp_dur;
    logic                   push_ge_cap;
    logic                   near;

    assign elapsed_w   = TIMER_WIDTH'(item.elapsed_ms);
    assign fclose_dur  = 18'(cfg.fill_ms) + 18'(cfg.release_ms);
    assign clamp_dur   = 18'(cfg.fill_ms) + {1'b0, cfg.release_ms, 1'b0};
    assign push_ge_cap = (cfg.push_ms >= cfg.cap_ms);

    brs_near u_near (
        .echo_us           (item.echo_us),
        .near_threshold_cm (cfg.near_threshold_cm),
        .near              (near)
    );

    always_comb begin
        brs_pkg::ctrl_t         c;
        logic [6:0]             p;
        logic [TIMER_WIDTH-1:0] r [7];

        c = ctrl_cur;
        p = pend_cur;

        // Age every pending timer, stopping at zero.
        for (int k = 0; k < brs_pkg::NUM_TIMERS; k++) begin
            if (p[k] && (rem_cur[k] > elapsed_w)) begin
                r[k] = rem_cur[k] - elapsed_w;
            end else if (p[k]) begin
                r[k] = '0;
            end else begin
                r[k] = rem_cur[k];
            end
        end

        // Start the current step when it is idle.
        if (!c.busy) begin
            case (c.step)
                brs_pkg::STEP_LOAD: begin
                    if (!c.loading) begin
                        c.busy    = 1'b1;
                        c.loading = 1'b1;
                        c.belt    = 1'b1;
                        p[brs_pkg::T_BELT] = 1'b1;
                        r[brs_pkg::T_BELT] = sat_dur(18'(cfg.belt_timeout_ms));
                    end
                end
                brs_pkg::STEP_PUSH: begin
                    c.busy = 1'b1;
                    c.push = 1'b1;
                    c.cap  = 1'b1;
                    p[brs_pkg::T_PUSH] = 1'b1;
                    r[brs_pkg::T_PUSH] = sat_dur(18'(cfg.push_ms));
                    p[brs_pkg::T_CAP]  = 1'b1;
                    r[brs_pkg::T_CAP]  = sat_dur(18'(cfg.cap_ms));
                end
                brs_pkg::STEP_FILL: begin
                    c.busy  = 1'b1;
                    c.clamp = 1'b1;
                    if (!c.loading) begin
                        c.loading = 1'b1;
                        c.belt    = 1'b1;
                        p[brs_pkg::T_BELT] = 1'b1;
                        r[brs_pkg::T_BELT] = sat_dur(18'(cfg.belt_timeout_ms));
                    end
                    p[brs_pkg::T_FOPEN]  = 1'b1;
                    r[brs_pkg::T_FOPEN]  = sat_dur(18'(cfg.release_ms));
                    p[brs_pkg::T_FCLOSE] = 1'b1;
                    r[brs_pkg::T_FCLOSE] = sat_dur(fclose_dur);
                    p[brs_pkg::T_CLAMP]  = 1'b1;
                    r[brs_pkg::T_CLAMP]  = sat_dur(clamp_dur);
                end
                default: begin
                end
            endcase
        end

        // Fire expired timers in priority order; later ones see earlier effects.
        if (p[brs_pkg::T_BELT] && (r[brs_pkg::T_BELT] == '0)) begin
            p[brs_pkg::T_BELT] = 1'b0;
            if (c.detect) begin
                c.belt = 1'b0;
            end
        end
        if (p[brs_pkg::T_PUSH] && (r[brs_pkg::T_PUSH] == '0)) begin
            p[brs_pkg::T_PUSH] = 1'b0;
            if (c.step == brs_pkg::STEP_PUSH) begin
                c.push = 1'b0;
            end
            if (push_ge_cap) begin
                c.step = brs_pkg::STEP_FILL;
                c.busy = 1'b0;
            end
        end
        if (p[brs_pkg::T_CAP] && (r[brs_pkg::T_CAP] == '0)) begin
            p[brs_pkg::T_CAP] = 1'b0;
            c.cap = 1'b0;
            if (!push_ge_cap) begin
                c.step = brs_pkg::STEP_FILL;
                c.busy = 1'b0;
            end
        end
        if (p[brs_pkg::T_FOPEN] && (r[brs_pkg::T_FOPEN] == '0)) begin
            p[brs_pkg::T_FOPEN] = 1'b0;
            c.fill = 1'b1;
        end
        if (p[brs_pkg::T_FCLOSE] && (r[brs_pkg::T_FCLOSE] == '0)) begin
            p[brs_pkg::T_FCLOSE] = 1'b0;
            c.fill = 1'b0;
        end
        if (p[brs_pkg::T_CLAMP] && (r[brs_pkg::T_CLAMP] == '0)) begin
            p[brs_pkg::T_CLAMP] = 1'b0;
            c.clamp = 1'b0;
            c.step  = brs_pkg::STEP_LOAD;
            c.busy  = 1'b0;
        end
        if (p[brs_pkg::T_SETTLE] && (r[brs_pkg::T_SETTLE] == '0)) begin
            p[brs_pkg::T_SETTLE] = 1'b0;
            p[brs_pkg::T_BELT]   = 1'b0;
            c.detect = 1'b0;
            c.belt   = 1'b0;
            if (c.step == brs_pkg::STEP_LOAD) begin
                c.step = brs_pkg::STEP_PUSH;
                c.busy = 1'b0;
            end
        end

        // A near bottle opens the settle window.
        if (!c.detect && near) begin
            c.detect  = 1'b1;
            c.loading = 1'b0;
            p[brs_pkg::T_SETTLE] = 1'b1;
            r[brs_pkg::T_SETTLE] = sat_dur(18'(cfg.settle_ms));
        end

        ctrl_next = c;
        pend_next = p;
        rem_next  = r;
    end

endmodule

### rtl/bottling_relay_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Bottling relay sequencer unit
// Relay sequencer for a three-step bottling cycle driven by control passes.
// ----------------------------------------------------------------------------
// Each input word is one control pass carrying the time since the previous
// pass and an ultrasonic echo width; each pass yields exactly one result word
// with the five relay levels, the current step and the busy and bottle flags.
// The unit accepts one word per clock cycle while the result side does not
// stall. A word waits in an input register, then a single combinational pass
// (timer aging, step start, timer firing, bottle check) updates the sequencer
// state and loads the result register, from which the result port presents it.
// While the result register is full and not taken, the input register still
// accepts one more word. Configuration registers are written through the
// cfg_we port and must only change while no word is in flight.
// ----------------------------------------------------------------------------
`include "bottling_relay_sequencer_unit_defines.svh"

module bottling_relay_sequencer_unit #(
    parameter int TIMER_WIDTH = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input words, one control pass each.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  brs_pkg::in_t                        s_data,

    // Result words.
    output logic                                m_valid,
    input  logic                                m_ready,
    output brs_pkg::out_t                       m_data,

    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [brs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [brs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // Configuration registers.
    brs_pkg::cfg_t          cfg_reg;

    // Input register.
    logic                   in_valid_reg;
    brs_pkg::in_t           in_data_reg;

    // Result register.
    logic                   out_valid_reg;
    brs_pkg::out_t          out_data_reg;

    // Sequencer state: control flags, timer pending bits and countdowns.
    brs_pkg::ctrl_t         ctrl_reg;
    brs_pkg::ctrl_t         ctrl_next;
    logic [6:0]             pend_reg;
    logic [6:0]             pend_next;
    logic [TIMER_WIDTH-1:0] rem_reg  [7];
    logic [TIMER_WIDTH-1:0] rem_next [7];

    logic                   advance;

    // A pass runs when a word waits and the result register can take its result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= brs_pkg::CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                brs_pkg::CFG_NEAR_THRESHOLD: cfg_reg.near_threshold_cm <= cfg_wdata[8:0];
                brs_pkg::CFG_BELT_TIMEOUT:   cfg_reg.belt_timeout_ms   <= cfg_wdata;
                brs_pkg::CFG_PUSH:           cfg_reg.push_ms           <= cfg_wdata;
                brs_pkg::CFG_CAP:            cfg_reg.cap_ms            <= cfg_wdata;
                brs_pkg::CFG_FILL:           cfg_reg.fill_ms           <= cfg_wdata;
                brs_pkg::CFG_RELEASE:        cfg_reg.release_ms        <= cfg_wdata;
                brs_pkg::CFG_SETTLE:         cfg_reg.settle_ms         <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The control pass itself.
    brs_pass #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_pass (
        .cfg       (cfg_reg),
        .item      (in_data_reg),
        .ctrl_cur  (ctrl_reg),
        .pend_cur  (pend_reg),
        .rem_cur   (rem_reg),
        .ctrl_next (ctrl_next),
        .pend_next (pend_next),
        .rem_next  (rem_next)
    );

    // Handshake control and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= brs_pkg::CTRL_RESET;
            pend_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                pend_reg      <= pend_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers. A countdown is only meaningful while its timer is
    // pending, so the countdowns need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            rem_reg                   <= rem_next;
            out_data_reg.clamp_on     <= ctrl_next.clamp;
            out_data_reg.cap_on       <= ctrl_next.cap;
            out_data_reg.push_on      <= ctrl_next.push;
            out_data_reg.fill_on      <= ctrl_next.fill;
            out_data_reg.belt_on      <= ctrl_next.belt;
            out_data_reg.current_step <= ctrl_next.step;
            out_data_reg.step_busy    <= ctrl_next.busy;
            out_data_reg.bottle_seen  <= ctrl_next.detect;
        end
    end

    // A word that completes its pass shows up as a result in the next cycle.
    `BRS_ASSERT_NEXT(a_pass_gives_result, aclk, aresetn, advance, m_valid)

    // The settle window and the settle timer open and close together.
    `BRS_ASSERT_SAME(a_detect_tracks_settle, aclk, aresetn, 1'b1, ctrl_reg.detect == pend_reg[brs_pkg::T_SETTLE])

    // The unused step code is never reported.
    `BRS_ASSERT_SAME(a_step_code_used, aclk, aresetn, m_valid, m_data.current_step != brs_pkg::STEP_NONE)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottling relay sequencer regression bench
// Drives control-pass words through the sequencer and compares every result
// word against a cycle-free model of the relay steps and one-shot timers,
// first with a short scripted sequence, then with random passes under
// randomly drawn register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int TIMER_W = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_PASSES = 150;

    // Index 7 is not a register; a write to it must change nothing.
    localparam logic [brs_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    localparam logic [19:0] ECHO_FAR = 20'hFFFFF;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [TIMER_W-1:0] TIMER_CEIL = '1;

    // ------------------------------------------------------------------
    // Clock, reset and the unit's ports
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic s_valid;
    logic s_ready;
    brs_pkg::in_t s_data;

    logic m_valid;
    logic m_ready = 1'b0;
    brs_pkg::out_t m_data;

    logic cfg_we;
    logic [brs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [brs_pkg::CFG_DATA_W-1:0] cfg_wdata;

    always #5 aclk = ~aclk;

    bottling_relay_sequencer_unit #(
        .TIMER_WIDTH(TIMER_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Sequencer model. It mirrors the unit's registers, relay levels and
    // the seven countdown timers, and is stepped once per accepted word.
    // ------------------------------------------------------------------
    brs_pkg::cfg_t relay_cfg;
    brs_pkg::step_t seq_step;
    logic seq_busy;
    logic seq_detect;
    logic seq_loading;
    logic rly_clamp;
    logic rly_cap;
    logic rly_push;
    logic rly_fill;
    logic rly_belt;
    logic tmr_armed [brs_pkg::NUM_TIMERS];
    logic [TIMER_W-1:0] tmr_left [brs_pkg::NUM_TIMERS];

    // Results the unit still owes, oldest first.
    brs_pkg::out_t pending_relay_words[$];

    int mismatch_count = 0;
    int sent_count = 0;
    int taken_count = 0;
    int quiet_cycles = 0;
    int sink_wait = 0;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;

    function void reset_sequencer_model();
        relay_cfg.near_threshold_cm = 9'd4;
        relay_cfg.belt_timeout_ms = 16'd60000;
        relay_cfg.push_ms = 16'd2500;
        relay_cfg.cap_ms = 16'd1000;
        relay_cfg.fill_ms = 16'd16000;
        relay_cfg.release_ms = 16'd1000;
        relay_cfg.settle_ms = 16'd1000;
        seq_step = brs_pkg::STEP_LOAD;
        seq_busy = 1'b0;
        seq_detect = 1'b0;
        seq_loading = 1'b0;
        {rly_clamp, rly_cap, rly_push, rly_fill, rly_belt} = '0;
        for (int k = 0; k < brs_pkg::NUM_TIMERS; k++) begin
            tmr_armed[k] = 1'b0;
            tmr_left[k] = '0;
        end
    endfunction

    // Arming a timer that is already running simply restarts it. Durations
    // beyond the timer range saturate.
    function void arm_timer(int k, int unsigned dur);
        tmr_armed[k] = 1'b1;
        tmr_left[k] = (dur > TIMER_CEIL) ? TIMER_CEIL : dur[TIMER_W-1:0];
    endfunction

    function void begin_loading();
        seq_loading = 1'b1;
        rly_belt = 1'b1;
        arm_timer(brs_pkg::T_BELT, relay_cfg.belt_timeout_ms);
    endfunction

    // One control pass: age the timers, start an idle step, fire expired
    // timers in slot order, then look for a near bottle.
    function brs_pkg::out_t advance_sequencer(brs_pkg::in_t w);
        brs_pkg::out_t r;
        int unsigned echo;
        int unsigned distance_cm;

        for (int k = 0; k < brs_pkg::NUM_TIMERS; k++) begin
            if (tmr_armed[k]) begin
                tmr_left[k] = (tmr_left[k] > w.elapsed_ms) ? tmr_left[k] - w.elapsed_ms : '0;
            end
        end

        if (!seq_busy) begin
            case (seq_step)
                brs_pkg::STEP_LOAD: begin
                    // A load that is already under way is not restarted.
                    if (!seq_loading) begin
                        seq_busy = 1'b1;
                        begin_loading();
                    end
                end
                brs_pkg::STEP_PUSH: begin
                    seq_busy = 1'b1;
                    rly_push = 1'b1;
                    rly_cap = 1'b1;
                    arm_timer(brs_pkg::T_PUSH, relay_cfg.push_ms);
                    arm_timer(brs_pkg::T_CAP, relay_cfg.cap_ms);
                end
                brs_pkg::STEP_FILL: begin
                    seq_busy = 1'b1;
                    rly_clamp = 1'b1;
                    if (!seq_loading) begin
                        begin_loading();
                    end
                    arm_timer(brs_pkg::T_FOPEN, relay_cfg.release_ms);
                    arm_timer(brs_pkg::T_FCLOSE,
                              int'(relay_cfg.fill_ms) + int'(relay_cfg.release_ms));
                    arm_timer(brs_pkg::T_CLAMP,
                              int'(relay_cfg.fill_ms) + 2 * int'(relay_cfg.release_ms));
                end
                default: ;
            endcase
        end

        for (int k = 0; k < brs_pkg::NUM_TIMERS; k++) begin
            if (tmr_armed[k] && tmr_left[k] == '0) begin
                tmr_armed[k] = 1'b0;
                case (k)
                    brs_pkg::T_BELT: begin
                        if (seq_detect) rly_belt = 1'b0;
                    end
                    brs_pkg::T_PUSH: begin
                        if (seq_step == brs_pkg::STEP_PUSH) rly_push = 1'b0;
                        // Equal push and cap times: the push end closes the step.
                        if (relay_cfg.push_ms >= relay_cfg.cap_ms) begin
                            seq_step = brs_pkg::STEP_FILL;
                            seq_busy = 1'b0;
                        end
                    end
                    brs_pkg::T_CAP: begin
                        rly_cap = 1'b0;
                        if (relay_cfg.cap_ms > relay_cfg.push_ms) begin
                            seq_step = brs_pkg::STEP_FILL;
                            seq_busy = 1'b0;
                        end
                    end
                    brs_pkg::T_FOPEN: rly_fill = 1'b1;
                    brs_pkg::T_FCLOSE: rly_fill = 1'b0;
                    brs_pkg::T_CLAMP: begin
                        rly_clamp = 1'b0;
                        seq_step = brs_pkg::STEP_LOAD;
                        seq_busy = 1'b0;
                    end
                    default: begin
                        // Settle window over: belt stops and loading hands over.
                        seq_detect = 1'b0;
                        rly_belt = 1'b0;
                        tmr_armed[brs_pkg::T_BELT] = 1'b0;
                        if (seq_step == brs_pkg::STEP_LOAD) begin
                            seq_step = brs_pkg::STEP_PUSH;
                            seq_busy = 1'b0;
                        end
                    end
                endcase
            end
        end

        // Distance in cm from the echo width; an echo of zero reads as near.
        echo = w.echo_us;
        distance_cm = (echo * 17) / 1000;
        if (!seq_detect && distance_cm <= relay_cfg.near_threshold_cm) begin
            seq_detect = 1'b1;
            seq_loading = 1'b0;
            arm_timer(brs_pkg::T_SETTLE, relay_cfg.settle_ms);
        end

        r.clamp_on = rly_clamp;
        r.cap_on = rly_cap;
        r.push_on = rly_push;
        r.fill_on = rly_fill;
        r.belt_on = rly_belt;
        r.current_step = seq_step;
        r.step_busy = seq_busy;
        r.bottle_seen = seq_detect;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. All drives happen at the falling edge; acceptance is
    // observed at the rising edge.
    // ------------------------------------------------------------------

    // Present one word, wait for the handshake and record its expectation.
    // A typed expectation, where given, replaces the model's answer, but the
    // model is stepped either way so its state stays in line.
    task automatic drive_pass(input brs_pkg::in_t w, input bit typed,
                              input brs_pkg::out_t want);
        int gap;
        brs_pkg::out_t predicted;

        sent_count++;
        if (sent_count % 25 == 0) src_calm = ($urandom_range(0, 3) == 0);
        gap = src_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_sequencer(w);
        pending_relay_words.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // Hold the sender off until every owed result has been taken, then
    // wait for the pipeline to empty completely.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_relay_words.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Leaves the write enable high, so back-to-back writes need no gap; the
    // caller lowers it once the batch is done.
    task automatic write_reg(input logic [brs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [brs_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            brs_pkg::CFG_NEAR_THRESHOLD: relay_cfg.near_threshold_cm = val[8:0];
            brs_pkg::CFG_BELT_TIMEOUT: relay_cfg.belt_timeout_ms = val;
            brs_pkg::CFG_PUSH: relay_cfg.push_ms = val;
            brs_pkg::CFG_CAP: relay_cfg.cap_ms = val;
            brs_pkg::CFG_FILL: relay_cfg.fill_ms = val;
            brs_pkg::CFG_RELEASE: relay_cfg.release_ms = val;
            brs_pkg::CFG_SETTLE: relay_cfg.settle_ms = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Durations lean on the extremes and on short times, so that whole step
    // cycles complete within a phase.
    function automatic logic [15:0] draw_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return 16'd0;
        if (r < 30) return 16'hFFFF;
        if (r < 75) return 16'($urandom_range(1, 3000));
        return 16'($urandom());
    endfunction

    task automatic randomize_settings();
        logic [15:0] push_val;
        logic [15:0] cap_val;
        int unsigned r;

        drain_results();
        r = $urandom_range(0, 99);
        if (r < 20) write_reg(brs_pkg::CFG_NEAR_THRESHOLD, 16'd0);
        else if (r < 35) write_reg(brs_pkg::CFG_NEAR_THRESHOLD, 16'd400);
        else write_reg(brs_pkg::CFG_NEAR_THRESHOLD, 16'($urandom_range(0, 400)));
        write_reg(brs_pkg::CFG_BELT_TIMEOUT, draw_duration());
        push_val = draw_duration();
        cap_val = ($urandom_range(0, 3) == 0) ? push_val : draw_duration();
        write_reg(brs_pkg::CFG_PUSH, push_val);
        write_reg(brs_pkg::CFG_CAP, cap_val);
        write_reg(brs_pkg::CFG_FILL, draw_duration());
        write_reg(brs_pkg::CFG_RELEASE, draw_duration());
        write_reg(brs_pkg::CFG_SETTLE, draw_duration());
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, 16'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // Random pass: echoes cluster around the present near threshold so that
    // detections are frequent, and elapsed times range from none to maximum.
    function automatic brs_pkg::in_t draw_pass();
        brs_pkg::in_t w;
        int unsigned near_top;
        int unsigned r;

        near_top = (int'(relay_cfg.near_threshold_cm) * 1000 + 999) / 17;
        r = $urandom_range(0, 99);
        if (r < 8) w.echo_us = '0;
        else if (r < 35) w.echo_us = 20'($urandom_range(0, near_top));
        else if (r < 45) w.echo_us = 20'(near_top + $urandom_range(0, 1));
        else w.echo_us = 20'($urandom());

        r = $urandom_range(0, 99);
        if (r < 15) w.elapsed_ms = '0;
        else if (r < 55) w.elapsed_ms = 16'($urandom_range(0, 2500));
        else if (r < 80) w.elapsed_ms = 16'($urandom_range(0, 20000));
        else if (r < 93) w.elapsed_ms = 16'($urandom());
        else w.elapsed_ms = ELAPSED_MAX;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Scripted opening sequence. Register writes and passes share one list;
    // a pass row carries a typed expectation only where it is obvious.
    // ------------------------------------------------------------------
    typedef struct {
        bit is_write;
        logic [brs_pkg::CFG_INDEX_W-1:0] idx;
        logic [brs_pkg::CFG_DATA_W-1:0] val;
        brs_pkg::in_t w;
        bit typed;
        brs_pkg::out_t want;
    } script_row_t;

    script_row_t opening_script[$];

    function void add_pass(logic [15:0] elapsed, logic [19:0] echo);
        script_row_t row;
        row = '{default: '0};
        row.w.elapsed_ms = elapsed;
        row.w.echo_us = echo;
        opening_script.push_back(row);
    endfunction

    function void add_typed(logic [15:0] elapsed, logic [19:0] echo, brs_pkg::out_t want);
        add_pass(elapsed, echo);
        opening_script[opening_script.size() - 1].typed = 1'b1;
        opening_script[opening_script.size() - 1].want = want;
    endfunction

    function void add_reg(logic [brs_pkg::CFG_INDEX_W-1:0] idx,
                          logic [brs_pkg::CFG_DATA_W-1:0] val);
        script_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx = idx;
        row.val = val;
        opening_script.push_back(row);
    endfunction

    function void build_opening_script();
        brs_pkg::out_t want;

        // Reset settings. The first pass starts loading: belt on, busy.
        want = '{clamp_on: 1'b0, cap_on: 1'b0, push_on: 1'b0, fill_on: 1'b0,
                 belt_on: 1'b1, current_step: brs_pkg::STEP_LOAD, step_busy: 1'b1,
                 bottle_seen: 1'b0};
        add_typed(16'd0, ECHO_FAR, want);
        // A zero echo is a near bottle and opens the settle window.
        want.bottle_seen = 1'b1;
        add_typed(16'd0, 20'd0, want);
        add_pass(16'd1000, ECHO_FAR);
        add_pass(16'd0, ECHO_FAR);
        add_pass(ELAPSED_MAX, ECHO_FAR);
        add_pass(16'd0, ECHO_FAR);
        add_pass(ELAPSED_MAX, 20'hFFFFF);
        // Back in the load step while still loading: nothing starts.
        add_pass(16'd0, ECHO_FAR);
        // Echo widths just outside and just inside a 4 cm threshold.
        add_pass(16'd0, 20'd295);
        add_pass(16'd0, 20'd294);

        // Equal push and cap times, zero durations everywhere else, and a
        // threshold of zero. The spare index must leave all of this intact.
        add_reg(brs_pkg::CFG_PUSH, 16'd500);
        add_reg(brs_pkg::CFG_CAP, 16'd500);
        add_reg(brs_pkg::CFG_RELEASE, 16'd0);
        add_reg(brs_pkg::CFG_FILL, 16'd0);
        add_reg(brs_pkg::CFG_SETTLE, 16'd0);
        add_reg(brs_pkg::CFG_BELT_TIMEOUT, 16'd0);
        add_reg(brs_pkg::CFG_NEAR_THRESHOLD, 16'd0);
        add_reg(CFG_SPARE, 16'hFFFF);
        add_pass(16'd1000, 20'd59);
        add_pass(16'd0, 20'd58);
        add_pass(16'd500, ECHO_FAR);
        add_pass(16'd0, ECHO_FAR);
        add_pass(16'd0, ECHO_FAR);

        // Longest settle window and widest threshold. The pass at 20000 ms
        // restarts a belt timeout that is still running, which the two
        // 15000 ms passes then tell apart from one that was not restarted.
        add_reg(brs_pkg::CFG_BELT_TIMEOUT, 16'd30000);
        add_reg(brs_pkg::CFG_SETTLE, 16'hFFFF);
        add_reg(brs_pkg::CFG_NEAR_THRESHOLD, 16'd400);
        add_reg(brs_pkg::CFG_PUSH, 16'hFFFF);
        add_reg(brs_pkg::CFG_CAP, 16'd0);
        add_pass(16'd0, 20'd0);
        add_pass(ELAPSED_MAX, 20'd0);
        add_pass(16'd0, ECHO_FAR);
        add_pass(ELAPSED_MAX, ECHO_FAR);
        add_pass(16'd0, 20'd0);
        add_pass(16'd20000, ECHO_FAR);
        add_pass(16'd15000, ECHO_FAR);
        add_pass(16'd15000, ECHO_FAR);
        add_pass(ELAPSED_MAX, ECHO_FAR);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls on m_ready and the field-by-field check.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (sink_wait > 0) begin
            m_ready <= 1'b0;
            sink_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        brs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_relay_words.size() == 0) begin
                mismatch_count++;
                $error("result word with no pass outstanding");
            end else begin
                want = pending_relay_words.pop_front();
                check_field("clamp_on", want.clamp_on, m_data.clamp_on);
                check_field("cap_on", want.cap_on, m_data.cap_on);
                check_field("push_on", want.push_on, m_data.push_on);
                check_field("fill_on", want.fill_on, m_data.fill_on);
                check_field("belt_on", want.belt_on, m_data.belt_on);
                check_field("current_step", want.current_step, m_data.current_step);
                check_field("step_busy", want.step_busy, m_data.step_busy);
                check_field("bottle_seen", want.bottle_seen, m_data.bottle_seen);
            end
            // The receiver's stall before the next word; now and then it
            // runs without any stall for a stretch.
            taken_count++;
            if (taken_count % 25 == 0) sink_calm = ($urandom_range(0, 3) == 0);
            sink_wait = sink_calm ? 0 : $urandom_range(0, 11);
        end
    end

    // The run ends as failed if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("bottling_relay_sequencer_unit regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit writing;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        writing = 1'b0;
        reset_sequencer_model();
        build_opening_script();

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Register writes only go in once every owed result is back.
        foreach (opening_script[i]) begin
            if (opening_script[i].is_write) begin
                if (!writing) begin
                    drain_results();
                    writing = 1'b1;
                end
                write_reg(opening_script[i].idx, opening_script[i].val);
            end else begin
                if (writing) begin
                    cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                drive_pass(opening_script[i].w, opening_script[i].typed,
                           opening_script[i].want);
            end
        end

        // Random phases, each under freshly drawn settings. Now and then the
        // sender also waits mid-phase until the unit has gone quiet.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_settings();
            for (int n = 0; n < PHASE_PASSES; n++) begin
                if ($urandom_range(0, 59) == 0) drain_results();
                drive_pass(draw_pass(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("bottling_relay_sequencer_unit regression: pass");
        end else begin
            $display("bottling_relay_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
